// ===== rtl/hbc_pkg.sv =====
// Shared constants and types for the histogram bin counter.
package hbc_pkg;

  localparam int MAX_BINS   = 32;
  localparam int COUNT_BITS = 32;
  localparam int BIN_CAP    = (MAX_BINS < 32) ? MAX_BINS : 32;
  localparam int BIN_AW     = $clog2(MAX_BINS);
  localparam int VAL_W      = 32;
  localparam int IDX_W      = 5;
  localparam int NB_W       = 6;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_EDGE  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_WB
  } state_t;

  typedef struct packed {
    logic                    we;
    logic [IDX_W-1:0]        idx;
    logic signed [VAL_W-1:0] value;
  } edge_wr_t;

endpackage

// ===== rtl/hbc_edge_match.sv =====
// Edge registers with a parallel compare and first-match bin select.
module hbc_edge_match
  import hbc_pkg::*;
(
  input  logic                    clk,
  input  edge_wr_t                edge_wr,
  input  logic signed [VAL_W-1:0] value,
  input  logic [NB_W-1:0]         nb,
  output logic [IDX_W-1:0]        bin
);

  logic signed [VAL_W-1:0] edge_r [1:BIN_CAP-1];

  always_ff @(posedge clk) begin
    for (int i = 1; i < BIN_CAP; i++) begin
      if (edge_wr.we && (edge_wr.idx == IDX_W'(i))) begin
        edge_r[i] <= edge_wr.value;
      end
    end
  end

  // Lowest bin whose upper neighbor's edge lies above the value wins.
  always_comb begin
    bin = IDX_W'(nb - NB_W'(1));
    for (int i = BIN_CAP - 1; i >= 1; i--) begin
      if ((NB_W'(i) < nb) && (value < edge_r[i])) begin
        bin = IDX_W'(i - 1);
      end
    end
  end

endmodule

// ===== rtl/histogram_bin_counter.sv =====
// Top level of the histogram bin counter: sequencer, count memory and result register.
//
//   channel   direction   handshake           payload
//   in_       input       in_valid/in_stall    in_op, in_value, in_bin_index
//   out_      output      out_valid/out_stall  out_bin, out_count
//   cfg_      input       cfg_we               cfg_wdata (num_bins)
//
// Each item passes a compare stage, which compares edges and reads the count memory,
// then a writeback stage, which modifies and writes the count back; the registered
// read of the count memory sets this split. Reset clears counts at once through
// per-entry valid bits; no clearing pass. A stalled result holds the writeback stage,
// and a new item is taken only when idle or when the writeback stage completes.
module histogram_bin_counter
  import hbc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              in_op,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic [IDX_W-1:0]        in_bin_index,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [IDX_W-1:0]        out_bin,
  output logic [31:0]             out_count,
  input  logic                    cfg_we,
  input  logic [NB_W-1:0]         cfg_wdata
);

  state_t                  state_r, state_nxt;
  op_t                     op_r;
  logic signed [VAL_W-1:0] value_r;
  logic [IDX_W-1:0]        idx_r;
  logic [NB_W-1:0]         num_bins_r;
  logic [IDX_W-1:0]        bin_r;
  logic [COUNT_BITS-1:0]   mem_rd_r;
  logic [MAX_BINS-1:0]     cnt_vld_r;
  logic                    out_valid_r;
  logic [IDX_W-1:0]        out_bin_r;
  logic [31:0]             out_count_r, out_count_nxt;

  logic [COUNT_BITS-1:0]   cnt_mem [MAX_BINS];

  logic                    in_acc;
  logic                    wb_go;
  logic                    wb_fire;
  logic [NB_W-1:0]         nb;
  logic [IDX_W-1:0]        found_bin;
  logic [IDX_W-1:0]        rd_bin;
  logic [BIN_AW-1:0]       wb_addr;
  logic                    idx_ok;
  logic [COUNT_BITS-1:0]   cnt_cur;
  logic [COUNT_BITS-1:0]   cnt_inc;
  edge_wr_t                edge_wr;

  // Clamp bins in use to the supported range.
  always_comb begin
    if (num_bins_r < NB_W'(2)) begin
      nb = NB_W'(2);
    end else if (num_bins_r > NB_W'(BIN_CAP)) begin
      nb = NB_W'(BIN_CAP);
    end else begin
      nb = num_bins_r;
    end
  end

  hbc_edge_match u_edge_match (
    .clk     (clk),
    .edge_wr (edge_wr),
    .value   (value_r),
    .nb      (nb),
    .bin     (found_bin)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) state_nxt = S_CMP;
      end
      S_CMP: begin
        state_nxt = S_WB;
      end
      S_WB: begin
        if (wb_go) state_nxt = in_acc ? S_CMP : S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State outputs
  always_comb begin
    wb_go    = 1'b0;
    in_stall = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
      end
      S_CMP: begin
        in_stall = 1'b1;
      end
      S_WB: begin
        wb_go    = !out_valid_r || !out_stall;
        in_stall = !wb_go;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  assign in_acc  = in_valid && !in_stall;
  assign wb_fire = (state_r == S_WB) && wb_go;
  assign rd_bin  = (op_r == OP_ADD) ? found_bin : idx_r;
  assign wb_addr = BIN_AW'(bin_r);
  assign idx_ok  = (32'(idx_r) < MAX_BINS);

  assign cnt_cur = cnt_vld_r[wb_addr] ? mem_rd_r : '0;
  assign cnt_inc = (cnt_cur == '1) ? cnt_cur : cnt_cur + COUNT_BITS'(1);

  always_comb begin
    edge_wr.we    = wb_fire && (op_r == OP_EDGE) && (idx_r != '0)
                    && (32'(idx_r) < BIN_CAP);
    edge_wr.idx   = idx_r;
    edge_wr.value = value_r;
  end

  always_comb begin
    case (op_r)
      OP_ADD:   out_count_nxt = 32'(cnt_inc);
      OP_EDGE:  out_count_nxt = idx_ok ? 32'(cnt_cur) : '0;
      OP_CLEAR: out_count_nxt = '0;
      OP_READ:  out_count_nxt = idx_ok ? 32'(cnt_cur) : '0;
      default:  out_count_nxt = '0;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      num_bins_r  <= NB_W'(32);
      cnt_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) num_bins_r <= cfg_wdata;
      if (wb_fire && (op_r == OP_CLEAR)) begin
        cnt_vld_r <= '0;
      end else if (wb_fire && (op_r == OP_ADD)) begin
        cnt_vld_r[wb_addr] <= 1'b1;
      end
      if (wb_fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r    <= op_t'(in_op);
      value_r <= in_value;
      idx_r   <= in_bin_index;
    end
    if (state_r == S_CMP) bin_r <= rd_bin;
    if (wb_fire) begin
      out_bin_r   <= bin_r;
      out_count_r <= out_count_nxt;
    end
  end

  // Count memory: read in compare stage, write back in the next
  always_ff @(posedge clk) begin
    if (state_r == S_CMP) mem_rd_r <= cnt_mem[BIN_AW'(rd_bin)];
    if (wb_fire && (op_r == OP_ADD)) cnt_mem[wb_addr] <= cnt_inc;
  end

  assign out_valid = out_valid_r;
  assign out_bin   = out_bin_r;
  assign out_count = out_count_r;

  a_acc_to_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_CMP))
    else $error("accepted beat did not enter compare stage");

  a_cmp_to_wb: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |=> (state_r == S_WB))
    else $error("compare stage not followed by writeback");

  a_wb_result: assert property (@(posedge clk) disable iff (!rst_n)
    wb_fire |=> out_valid)
    else $error("writeback produced no result");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (wb_fire && (op_r == OP_CLEAR)) |=> ((cnt_vld_r == '0) && (out_count == '0)))
    else $error("clear left counts valid");

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the histogram bin counter: predictor, stimulus and result check.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import hbc_pkg::*;

  localparam int LONG_HOLD = 150;
  localparam int DRAIN_PAD = 6;

  typedef struct {
    logic [IDX_W-1:0] bin;
    logic [31:0]      count;
  } result_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [1:0]              in_op = '0;
  logic signed [VAL_W-1:0] in_value = '0;
  logic [IDX_W-1:0]        in_bin_index = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [IDX_W-1:0]        out_bin;
  logic [31:0]             out_count;
  logic                    cfg_we = 1'b0;
  logic [NB_W-1:0]         cfg_wdata = '0;

  // Shadow state of the histogram
  logic signed [VAL_W-1:0] lower_edge [MAX_BINS];
  logic [COUNT_BITS-1:0]   tally [MAX_BINS];
  logic [NB_W-1:0]         num_bins_q;

  result_t pending_results[$];
  int      errors = 0;
  int      beats_sent = 0;
  int      adds_sent = 0;
  int      results_seen = 0;
  int      in_stall_cycles = 0;
  int      settings_used = 0;
  bit      quiet = 1'b0;
  int      hold_req = 0;
  int      hold_seen = 0;
  int      stall_left = 0;

  histogram_bin_counter i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_value     (in_value),
    .in_bin_index (in_bin_index),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_bin      (out_bin),
    .out_count    (out_count),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  // Apply one accepted beat to the shadow histogram and return the expected result.
  function automatic result_t update_histogram(op_t op, logic signed [VAL_W-1:0] v,
                                               logic [IDX_W-1:0] idx);
    result_t r;
    int      nb;
    int      b;
    r.bin   = idx;
    r.count = '0;
    case (op)
      OP_ADD: begin
        nb = num_bins_q;
        if (nb < 2) nb = 2;
        if (nb > BIN_CAP) nb = BIN_CAP;
        // First-match scan: stop below the next bin's lower edge
        b = 0;
        while (b + 1 < nb && v >= lower_edge[b + 1]) b++;
        if (tally[b] != '1) tally[b]++;
        r.bin   = IDX_W'(b);
        r.count = 32'(tally[b]);
      end
      OP_EDGE: begin
        if (idx < MAX_BINS) begin
          if (idx != 0) lower_edge[idx] = v;
          r.count = 32'(tally[idx]);
        end
      end
      OP_CLEAR: begin
        foreach (tally[i]) tally[i] = '0;
      end
      default: begin
        if (idx < MAX_BINS) r.count = 32'(tally[idx]);
      end
    endcase
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return lower_edge[$urandom_range(1, MAX_BINS - 1)] + 32'($urandom_range(0, 4)) - 32'd2;
    if (r < 6) return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    return $urandom;
  endfunction

  // Offer one beat after a random gap; hold it until accepted.
  task automatic send_beat(op_t op, logic signed [VAL_W-1:0] v, logic [IDX_W-1:0] idx);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_op        <= op;
    in_value     <= v;
    in_bin_index <= idx;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(update_histogram(op, v, idx));
    beats_sent++;
    if (op == OP_ADD) adds_sent++;
  endtask

  task automatic random_beat();
    int                      r;
    op_t                     op;
    logic signed [VAL_W-1:0] v;
    logic [IDX_W-1:0]        idx;
    r   = $urandom_range(0, 99);
    idx = IDX_W'($urandom_range(0, MAX_BINS - 1));
    v   = $urandom;
    if (r < 60) begin
      op = OP_ADD;
      v  = pick_sample();
    end else if (r < 75) begin
      op = OP_EDGE;
      if ($urandom_range(0, 1)) v = pick_sample();
    end else if (r < 78) begin
      op = OP_CLEAR;
    end else begin
      op = OP_READ;
    end
    send_beat(op, v, idx);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  task automatic set_num_bins(logic [NB_W-1:0] n);
    cfg_we    <= 1'b1;
    cfg_wdata <= n;
    @(posedge clk);
    num_bins_q = n;
    settings_used++;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_edges(bit ascending);
    int vals[$];
    for (int j = 1; j < MAX_BINS; j++) vals.push_back($urandom);
    if (ascending) vals.sort();
    for (int j = 1; j < MAX_BINS; j++) send_beat(OP_EDGE, vals[j - 1], IDX_W'(j));
  endtask

  // Every lower edge is written before the first add; bin 0 takes a write that must be dropped.
  task automatic test_edge_setup();
    for (int j = 0; j < MAX_BINS; j++) send_beat(OP_EDGE, (j - 16) * 32'sh0010_0000, IDX_W'(j));
  endtask

  task automatic test_directed();
    send_beat(OP_ADD, 32'sh8000_0000, 5'd0);
    send_beat(OP_ADD, 32'sh7FFF_FFFF, 5'd31);
    send_beat(OP_ADD, lower_edge[5], IDX_W'($urandom));
    send_beat(OP_ADD, lower_edge[5] - 1, IDX_W'($urandom));
    send_beat(OP_ADD, 32'sd0, IDX_W'($urandom));
    send_beat(OP_ADD, -32'sd1, IDX_W'($urandom));
    send_beat(OP_READ, $urandom, 5'd5);
    send_beat(OP_READ, $urandom, 5'd31);
    send_beat(OP_READ, $urandom, 5'd0);
    send_beat(OP_EDGE, 32'sh7FFF_FFFF, 5'd0);
    send_beat(OP_ADD, 32'sh8000_0000, 5'd31);
    send_beat(OP_CLEAR, -32'sd1, 5'd31);
    send_beat(OP_READ, 32'sd0, 5'd5);
    send_beat(OP_ADD, 32'sh7FFF_FFFF, 5'd0);
    send_beat(OP_READ, -32'sd1, 5'd31);
    drain();
  endtask

  // Sweep bins-in-use through its extremes and clamped values.
  task automatic test_bin_count_settings();
    logic [NB_W-1:0] bin_settings [9] = '{6'd2, 6'd0, 6'd1, 6'd63, 6'd33, 6'd17, 6'd3, 6'd31, 6'd32};
    foreach (bin_settings[k]) begin
      set_num_bins(bin_settings[k]);
      if (k == 4) load_edges(1'b1);
      quiet = (k == 2);
      repeat (38) random_beat();
      quiet = 1'b0;
      drain();
    end
  endtask

  // Hold the result side off while the sender keeps offering back-to-back beats.
  task automatic test_backpressure();
    quiet = 1'b1;
    hold_req++;
    repeat (40) random_beat();
    quiet = 1'b0;
    drain();
  endtask

  task automatic test_unordered_edges();
    load_edges(1'b0);
    repeat (50) random_beat();
    drain();
  endtask

  // Edges at the ends of the value range, with two equal edges.
  task automatic test_edge_extremes();
    set_num_bins(6'd5);
    send_beat(OP_EDGE, 32'sh8000_0000, 5'd1);
    send_beat(OP_EDGE, 32'sd0, 5'd2);
    send_beat(OP_EDGE, 32'sd0, 5'd3);
    send_beat(OP_EDGE, 32'sh7FFF_FFFF, 5'd4);
    send_beat(OP_ADD, 32'sh8000_0000, IDX_W'($urandom));
    send_beat(OP_ADD, -32'sd1, IDX_W'($urandom));
    send_beat(OP_ADD, 32'sd0, IDX_W'($urandom));
    send_beat(OP_ADD, 32'sh7FFF_FFFE, IDX_W'($urandom));
    send_beat(OP_ADD, 32'sh7FFF_FFFF, IDX_W'($urandom));
    send_beat(OP_READ, $urandom, 5'd3);
    send_beat(OP_CLEAR, $urandom, IDX_W'($urandom));
    send_beat(OP_READ, $urandom, 5'd1);
    drain();
  endtask

  // Result side: random stalls, a long hold on request, and calm stretches.
  always @(posedge clk) begin
    int r;
    if (hold_req != hold_seen) begin
      hold_seen  <= hold_req;
      stall_left <= LONG_HOLD;
      out_stall  <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (quiet || r < 60) begin
        out_stall <= 1'b0;
      end else if (r < 93) begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(0, 2);
      end else begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(8, 30);
      end
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && in_valid && in_stall) in_stall_cycles++;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("unexpected result beat: bin %0d count %0d", out_bin, out_count);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_bin !== want.bin) begin
          $error("bin: expected %0d, actual %0d", want.bin, out_bin);
          errors++;
        end
        if (out_count !== want.count) begin
          $error("count: expected %0d, actual %0d", want.count, out_count);
          errors++;
        end
      end
    end
  end

  initial begin
    foreach (tally[i]) begin
      tally[i]      = '0;
      lower_edge[i] = '0;
    end
    num_bins_q = 6'd32;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_edge_setup();
    test_directed();
    test_bin_count_settings();
    test_backpressure();
    test_unordered_edges();
    test_edge_extremes();
    $display("covered %0d input beats (%0d adds) and %0d checked results over %0d bin settings",
             beats_sent, adds_sent, results_seen, settings_used);
    $display("input side saw %0d stalled cycles; %0d mismatches", in_stall_cycles, errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
